// ----- hw/rtl/paged_memory_walker_allocator_defines.svh -----
// Assertion macros for the paged memory walker allocator.
`ifndef PAGED_MEMORY_WALKER_ALLOCATOR_DEFINES_SVH
`define PAGED_MEMORY_WALKER_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define PMWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PMWA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PMWA_ASSERT(lbl, prop, msg)
`define PMWA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/pmwa_pkg.sv -----
// Shared constants, types and datapath commands of the paged memory walker.
`default_nettype none
package pmwa_pkg;
  localparam int OFFSET_BITS = 4;
  localparam int LEVELS      = 4;
  localparam int FRAME_COUNT = 64;
  localparam int WORD_BITS   = 32;

  localparam int PAGE_WORDS = 1 << OFFSET_BITS;
  localparam int PN_BITS    = OFFSET_BITS * LEVELS;
  localparam int VA_BITS    = OFFSET_BITS * (LEVELS + 1);
  localparam int PAGE_COUNT = 1 << PN_BITS;
  localparam int FRAME_BITS = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int MEM_AW     = FRAME_BITS + OFFSET_BITS;
  localparam int MEM_WORDS  = FRAME_COUNT * PAGE_WORDS;
  localparam int SWAP_WORDS = PAGE_COUNT * PAGE_WORDS;
  localparam int LVL_BITS   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int DIST_BITS  = PN_BITS + 1;
  localparam int CLR_BITS   = (PN_BITS > MEM_AW) ? PN_BITS : MEM_AW;

  // access operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [WORD_BITS-1:0]   word_t;
  typedef logic [FRAME_BITS-1:0]  frame_t;
  typedef logic [PN_BITS-1:0]     vpn_t;
  typedef logic [OFFSET_BITS-1:0] idx_t;
  typedef logic [LVL_BITS-1:0]    lvl_t;
  typedef logic [DIST_BITS-1:0]   dist_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_CLR, CMD_LOAD, CMD_WRD, CMD_WEV, CMD_SCI, CMD_SCRD, CMD_SCEV,
    CMD_SCEND, CMD_SCNX, CMD_DECIDE, CMD_EVRD, CMD_EVWR, CMD_UNLK, CMD_FILL,
    CMD_PRCK, CMD_RSRD, CMD_RSWR, CMD_CLF, CMD_LINK, CMD_ACC, CMD_ACCW, CMD_DONE
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic entry_nz;
    logic lvl_last;
    logic push;
    logic j_last;
    logic depth_zero;
    logic use_zero;
    logic use_new;
    logic fail;
    logic i_last;
    logic present;
    logic is_write;
    logic out_free;
  } stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/paged_memory_walker_allocator.sv -----
// Top level of the paged memory walker allocator.
// Input channel (in_valid/in_ready) takes one access: in_operation (0 read,
// 1 write), in_virtual_address and in_write_data. Output channel
// (out_valid/out_ready) returns one item per access: the word read, or zero.
// One access is handled at a time. A read that hits on all levels does one
// table lookup per level (a read through the registered memory port, then an
// evaluation of the entry), then the data access; a write skips the read-back.
// Each missing level adds a depth-first scan of the page tables, reading each
// table word through the memory port. An unused frame is taken if there is
// one; otherwise a page is evicted to swap when one can be. The new frame is
// then restored from swap or cleared, and linked. The single physical memory
// port sets the cost of a missing level.
// After reset a clearing pass zeroes physical memory and the swap-present
// marks; in_ready stays low meanwhile.
// The result sits in an output register, so a stalled receiver does not stop
// the next access from being accepted and worked on; only its hand-off waits.
`include "paged_memory_walker_allocator_defines.svh"
`default_nettype none
module paged_memory_walker_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [19:0] in_virtual_address,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_read_data
);
  pmwa_pkg::cmd_t  cmd;
  pmwa_pkg::stat_t stat;

  // sequencer
  pmwa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .stat(stat), .cmd(cmd)
  );

  // memories and registers
  pmwa_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_operation(in_operation), .in_virtual_address(in_virtual_address),
    .in_write_data(in_write_data), .out_ready(out_ready),
    .out_valid(out_valid), .out_read_data(out_read_data), .stat(stat)
  );

  `PMWA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted while busy")
  `PMWA_ASSERT(a_no_accept_in_clear, (cmd == pmwa_pkg::CMD_CLR) |-> !in_ready, "ready in clear")
  `PMWA_ASSERT(a_done_gives_item, (cmd == pmwa_pkg::CMD_DONE) && stat.out_free |=> out_valid, "result lost")
  `PMWA_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_ready, "ready right after reset")
endmodule
`default_nettype wire

// ----- hw/rtl/pmwa_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module pmwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/pmwa_dp.sv -----
// Datapath: memories, walk and scan registers, eviction and output register.
`default_nettype none
module pmwa_dp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pmwa_pkg::cmd_t cmd,
  input  wire logic           in_operation,
  input  wire logic [19:0]    in_virtual_address,
  input  wire logic [31:0]    in_write_data,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [31:0]         out_read_data,
  output pmwa_pkg::stat_t     stat
);
  localparam int OB = pmwa_pkg::OFFSET_BITS;

  logic                         op_r;
  logic [pmwa_pkg::VA_BITS-1:0] va_r;
  pmwa_pkg::word_t              wdata_r;
  pmwa_pkg::lvl_t               lvl_r;
  pmwa_pkg::frame_t             wframe_r;
  pmwa_pkg::frame_t             next_r;
  pmwa_pkg::lvl_t               depth_r;
  pmwa_pkg::vpn_t               svpn_r;
  pmwa_pkg::word_t              maxf_r;
  logic                         zero_ok_r;
  pmwa_pkg::frame_t             zero_frame_r;
  pmwa_pkg::frame_t             zero_parent_r;
  pmwa_pkg::vpn_t               zero_vpn_r;
  pmwa_pkg::frame_t             vic_frame_r;
  pmwa_pkg::frame_t             vic_parent_r;
  pmwa_pkg::vpn_t               vic_vpn_r;
  pmwa_pkg::dist_t              vic_dist_r;
  pmwa_pkg::idx_t               i_r;
  logic [pmwa_pkg::CLR_BITS-1:0] clr_r;
  pmwa_pkg::word_t              result_r;
  logic                         out_valid_r;
  logic [31:0]                  out_data_r;

  pmwa_pkg::frame_t stk_frame_r  [pmwa_pkg::LEVELS];
  pmwa_pkg::frame_t stk_parent_r [pmwa_pkg::LEVELS];
  pmwa_pkg::idx_t   stk_j_r      [pmwa_pkg::LEVELS];
  logic             stk_az_r     [pmwa_pkg::LEVELS];

  // memory ports
  logic [pmwa_pkg::MEM_AW-1:0]  mem_addr;
  logic                         mem_we;
  pmwa_pkg::word_t              mem_wd;
  pmwa_pkg::word_t              mem_rdata;
  logic [pmwa_pkg::VA_BITS-1:0] swap_addr;
  logic                         swap_we;
  pmwa_pkg::word_t              swap_wd;
  pmwa_pkg::word_t              swap_rdata;
  pmwa_pkg::vpn_t               pres_addr;
  logic                         pres_we;
  logic                         pres_wd;
  logic                         pres_rdata;

  pmwa_ram #(.WIDTH(pmwa_pkg::WORD_BITS), .DEPTH(pmwa_pkg::MEM_WORDS)) u_pmem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wd), .rdata(mem_rdata)
  );
  pmwa_ram #(.WIDTH(pmwa_pkg::WORD_BITS), .DEPTH(pmwa_pkg::SWAP_WORDS)) u_swap (
    .clk(clk), .we(swap_we), .addr(swap_addr), .wdata(swap_wd), .rdata(swap_rdata)
  );
  pmwa_ram #(.WIDTH(1), .DEPTH(pmwa_pkg::PAGE_COUNT)) u_pres (
    .clk(clk), .we(pres_we), .addr(pres_addr), .wdata(pres_wd), .rdata(pres_rdata)
  );

  // decoded fields and scan terms
  pmwa_pkg::vpn_t   vpn;
  pmwa_pkg::idx_t   off;
  pmwa_pkg::idx_t   idx;
  logic             lvl_last;
  pmwa_pkg::frame_t cur_frame;
  pmwa_pkg::frame_t cur_parent;
  pmwa_pkg::idx_t   cur_j;
  logic             cur_az;
  logic             v_nz;
  logic             v_in;
  logic             child_leaf;
  logic             push;
  logic             j_last;
  pmwa_pkg::vpn_t   child_vpn;
  pmwa_pkg::vpn_t   dist_d;
  pmwa_pkg::dist_t  dist_alt;
  pmwa_pkg::dist_t  dist_m;
  logic             leaf_better;
  logic             zero_hit;
  logic [pmwa_pkg::WORD_BITS:0] maxf_p1;
  logic             use_zero;
  logic             use_new;
  logic             fail;
  logic             i_last;
  logic             out_free;

  always_comb begin
    vpn        = va_r[pmwa_pkg::VA_BITS-1:OB];
    off        = va_r[OB-1:0];
    idx        = pmwa_pkg::idx_t'(vpn >> (OB * (pmwa_pkg::LEVELS - 1 - int'(lvl_r))));
    lvl_last   = (lvl_r == pmwa_pkg::LVL_BITS'(pmwa_pkg::LEVELS - 1));
    cur_frame  = stk_frame_r[depth_r];
    cur_parent = stk_parent_r[depth_r];
    cur_j      = stk_j_r[depth_r];
    cur_az     = stk_az_r[depth_r];
    v_nz       = (mem_rdata != '0);
    v_in       = (mem_rdata < pmwa_pkg::word_t'(pmwa_pkg::FRAME_COUNT));
    child_leaf = ((int'(depth_r) + 1) == pmwa_pkg::LEVELS);
    push       = v_nz && v_in && !child_leaf;
    j_last     = (cur_j == '1);
    child_vpn  = pmwa_pkg::vpn_t'({svpn_r, cur_j});
    dist_d     = (vpn > child_vpn) ? (vpn - child_vpn) : (child_vpn - vpn);
    dist_alt   = pmwa_pkg::DIST_BITS'(pmwa_pkg::PAGE_COUNT) - {1'b0, dist_d};
    dist_m     = ({1'b0, dist_d} > dist_alt) ? dist_alt : {1'b0, dist_d};
    leaf_better = v_nz && v_in && child_leaf && (dist_m > vic_dist_r);
    zero_hit   = cur_az &&
                 ((vpn >> (OB * (pmwa_pkg::LEVELS - int'(depth_r)))) != svpn_r);
    maxf_p1    = {1'b0, maxf_r} + 1'b1;
    use_zero   = zero_ok_r &&
                 (maxf_p1 == (pmwa_pkg::WORD_BITS + 1)'(pmwa_pkg::FRAME_COUNT));
    use_new    = (maxf_p1 < (pmwa_pkg::WORD_BITS + 1)'(pmwa_pkg::FRAME_COUNT));
    fail       = !use_zero && !use_new && (vic_dist_r == '0);
    i_last     = (i_r == '1);
    out_free   = !out_valid_r || out_ready;
  end

  // status to the controller
  always_comb begin
    stat.clr_done   = (clr_r == '1);
    stat.entry_nz   = v_nz;
    stat.lvl_last   = lvl_last;
    stat.push       = push;
    stat.j_last     = j_last;
    stat.depth_zero = (depth_r == '0);
    stat.use_zero   = use_zero;
    stat.use_new    = use_new;
    stat.fail       = fail;
    stat.i_last     = i_last;
    stat.present    = pres_rdata;
    stat.is_write   = op_r;
    stat.out_free   = out_free;
  end

  // steer memory ports by command
  always_comb begin
    mem_addr  = '0;
    mem_we    = 1'b0;
    mem_wd    = '0;
    swap_addr = '0;
    swap_we   = 1'b0;
    swap_wd   = mem_rdata;
    pres_addr = '0;
    pres_we   = 1'b0;
    pres_wd   = 1'b0;
    case (cmd)
      pmwa_pkg::CMD_CLR: begin
        mem_we    = ({1'b0, clr_r} < (pmwa_pkg::CLR_BITS + 1)'(pmwa_pkg::MEM_WORDS));
        mem_addr  = pmwa_pkg::MEM_AW'(clr_r);
        pres_we   = ({1'b0, clr_r} < (pmwa_pkg::CLR_BITS + 1)'(pmwa_pkg::PAGE_COUNT));
        pres_addr = pmwa_pkg::PN_BITS'(clr_r);
      end
      pmwa_pkg::CMD_WRD:  mem_addr = {wframe_r, idx};
      pmwa_pkg::CMD_SCRD: mem_addr = {cur_frame, cur_j};
      pmwa_pkg::CMD_DECIDE: begin
        mem_we   = use_zero;
        mem_addr = {zero_parent_r, pmwa_pkg::idx_t'(zero_vpn_r)};
      end
      pmwa_pkg::CMD_EVRD: mem_addr = {vic_frame_r, i_r};
      pmwa_pkg::CMD_EVWR: begin
        swap_we   = 1'b1;
        swap_addr = {vic_vpn_r, i_r};
        mem_we    = 1'b1;
        mem_addr  = {vic_frame_r, i_r};
        pres_we   = i_last;
        pres_addr = vic_vpn_r;
        pres_wd   = 1'b1;
      end
      pmwa_pkg::CMD_UNLK: begin
        mem_we   = 1'b1;
        mem_addr = {vic_parent_r, pmwa_pkg::idx_t'(vic_vpn_r)};
      end
      pmwa_pkg::CMD_FILL: pres_addr = vpn;
      pmwa_pkg::CMD_RSRD: swap_addr = {vpn, i_r};
      pmwa_pkg::CMD_RSWR: begin
        mem_we    = 1'b1;
        mem_addr  = {next_r, i_r};
        mem_wd    = swap_rdata;
        pres_we   = i_last;
        pres_addr = vpn;
      end
      pmwa_pkg::CMD_CLF: begin
        mem_we   = 1'b1;
        mem_addr = {next_r, i_r};
      end
      pmwa_pkg::CMD_LINK: begin
        mem_we   = 1'b1;
        mem_addr = {wframe_r, idx};
        mem_wd   = pmwa_pkg::word_t'(next_r);
      end
      pmwa_pkg::CMD_ACC: begin
        mem_we   = op_r;
        mem_addr = {wframe_r, off};
        mem_wd   = wdata_r;
      end
      default: begin
        mem_addr = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd == pmwa_pkg::CMD_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd == pmwa_pkg::CMD_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    case (cmd)
      pmwa_pkg::CMD_LOAD: begin
        op_r     <= in_operation;
        va_r     <= in_virtual_address[pmwa_pkg::VA_BITS-1:0];
        wdata_r  <= pmwa_pkg::word_t'($signed(in_write_data));
        lvl_r    <= '0;
        wframe_r <= '0;
        result_r <= '0;
      end
      pmwa_pkg::CMD_WEV: begin
        if (v_nz) begin
          wframe_r <= pmwa_pkg::frame_t'(mem_rdata);
          if (!lvl_last) begin
            lvl_r <= lvl_r + 1'b1;
          end
        end
      end
      pmwa_pkg::CMD_SCI: begin
        depth_r         <= '0;
        stk_frame_r[0]  <= '0;
        stk_parent_r[0] <= '0;
        stk_j_r[0]      <= '0;
        stk_az_r[0]     <= 1'b1;
        svpn_r          <= '0;
        maxf_r          <= '0;
        zero_ok_r       <= 1'b0;
        vic_dist_r      <= '0;
      end
      pmwa_pkg::CMD_SCEV: begin
        if (mem_rdata > maxf_r) begin
          maxf_r <= mem_rdata;
        end
        if (v_nz) begin
          stk_az_r[depth_r] <= 1'b0;
        end
        if (leaf_better) begin
          vic_dist_r   <= dist_m;
          vic_frame_r  <= pmwa_pkg::frame_t'(mem_rdata);
          vic_parent_r <= cur_frame;
          vic_vpn_r    <= child_vpn;
        end
        // descend into a child table or step to the next entry
        if (push) begin
          depth_r                            <= depth_r + 1'b1;
          stk_frame_r[depth_r + 1'b1]        <= pmwa_pkg::frame_t'(mem_rdata);
          stk_parent_r[depth_r + 1'b1]       <= cur_frame;
          stk_j_r[depth_r + 1'b1]            <= '0;
          stk_az_r[depth_r + 1'b1]           <= 1'b1;
          svpn_r                             <= child_vpn;
        end else if (!j_last) begin
          stk_j_r[depth_r] <= cur_j + 1'b1;
        end
      end
      pmwa_pkg::CMD_SCEND: begin
        if (zero_hit) begin
          zero_ok_r     <= 1'b1;
          zero_frame_r  <= cur_frame;
          zero_parent_r <= cur_parent;
          zero_vpn_r    <= svpn_r;
        end
        if (depth_r != '0) begin
          depth_r <= depth_r - 1'b1;
          svpn_r  <= svpn_r >> OB;
        end
      end
      pmwa_pkg::CMD_SCNX: begin
        if (!j_last) begin
          stk_j_r[depth_r] <= cur_j + 1'b1;
        end
      end
      pmwa_pkg::CMD_DECIDE: begin
        if (use_zero) begin
          next_r <= zero_frame_r;
        end else if (use_new) begin
          next_r <= pmwa_pkg::frame_t'(maxf_p1);
        end
        i_r <= '0;
      end
      pmwa_pkg::CMD_EVWR: i_r <= i_r + 1'b1;
      pmwa_pkg::CMD_UNLK: next_r <= vic_frame_r;
      pmwa_pkg::CMD_FILL: i_r <= '0;
      pmwa_pkg::CMD_RSWR: i_r <= i_r + 1'b1;
      pmwa_pkg::CMD_CLF:  i_r <= i_r + 1'b1;
      pmwa_pkg::CMD_LINK: begin
        wframe_r <= next_r;
        if (!lvl_last) begin
          lvl_r <= lvl_r + 1'b1;
        end
      end
      pmwa_pkg::CMD_ACCW: result_r <= mem_rdata;
      pmwa_pkg::CMD_DONE: begin
        if (out_free) begin
          out_data_r <= result_r[31:0];
        end
      end
      default: begin
        op_r <= op_r;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
endmodule
`default_nettype wire

// ----- hw/rtl/pmwa_ctrl.sv -----
// Controller: sequences clearing, walk, scan, eviction, fill and access.
`default_nettype none
module pmwa_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire pmwa_pkg::stat_t stat,
  output pmwa_pkg::cmd_t       cmd
);
  typedef enum logic [21:0] {
    S_CLR    = 22'd1 << 0,
    S_IDLE   = 22'd1 << 1,
    S_WRD    = 22'd1 << 2,
    S_WEV    = 22'd1 << 3,
    S_SCI    = 22'd1 << 4,
    S_SCRD   = 22'd1 << 5,
    S_SCEV   = 22'd1 << 6,
    S_SCEND  = 22'd1 << 7,
    S_SCNX   = 22'd1 << 8,
    S_DECIDE = 22'd1 << 9,
    S_EVRD   = 22'd1 << 10,
    S_EVWR   = 22'd1 << 11,
    S_UNLK   = 22'd1 << 12,
    S_FILL   = 22'd1 << 13,
    S_PRCK   = 22'd1 << 14,
    S_RSRD   = 22'd1 << 15,
    S_RSWR   = 22'd1 << 16,
    S_CLF    = 22'd1 << 17,
    S_LINK   = 22'd1 << 18,
    S_ACC    = 22'd1 << 19,
    S_ACCW   = 22'd1 << 20,
    S_DONE   = 22'd1 << 21
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = pmwa_pkg::CMD_NOP;
    case (state_r)
      S_CLR: begin
        cmd = pmwa_pkg::CMD_CLR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd       = pmwa_pkg::CMD_LOAD;
          state_nxt = S_WRD;
        end
      end
      S_WRD: begin
        cmd       = pmwa_pkg::CMD_WRD;
        state_nxt = S_WEV;
      end
      S_WEV: begin
        cmd = pmwa_pkg::CMD_WEV;
        if (!stat.entry_nz)    state_nxt = S_SCI;
        else if (stat.lvl_last) state_nxt = S_ACC;
        else                   state_nxt = S_WRD;
      end
      S_SCI: begin
        cmd       = pmwa_pkg::CMD_SCI;
        state_nxt = S_SCRD;
      end
      S_SCRD: begin
        cmd       = pmwa_pkg::CMD_SCRD;
        state_nxt = S_SCEV;
      end
      S_SCEV: begin
        cmd = pmwa_pkg::CMD_SCEV;
        if (!stat.push && stat.j_last) state_nxt = S_SCEND;
        else                           state_nxt = S_SCRD;
      end
      S_SCEND: begin
        cmd = pmwa_pkg::CMD_SCEND;
        state_nxt = stat.depth_zero ? S_DECIDE : S_SCNX;
      end
      S_SCNX: begin
        cmd = pmwa_pkg::CMD_SCNX;
        state_nxt = stat.j_last ? S_SCEND : S_SCRD;
      end
      S_DECIDE: begin
        cmd = pmwa_pkg::CMD_DECIDE;
        if (stat.use_zero || stat.use_new) state_nxt = S_FILL;
        else if (stat.fail)                state_nxt = S_DONE;
        else                               state_nxt = S_EVRD;
      end
      S_EVRD: begin
        cmd       = pmwa_pkg::CMD_EVRD;
        state_nxt = S_EVWR;
      end
      S_EVWR: begin
        cmd = pmwa_pkg::CMD_EVWR;
        state_nxt = stat.i_last ? S_UNLK : S_EVRD;
      end
      S_UNLK: begin
        cmd       = pmwa_pkg::CMD_UNLK;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        cmd = pmwa_pkg::CMD_FILL;
        state_nxt = stat.lvl_last ? S_PRCK : S_CLF;
      end
      S_PRCK: begin
        cmd = pmwa_pkg::CMD_PRCK;
        state_nxt = stat.present ? S_RSRD : S_CLF;
      end
      S_RSRD: begin
        cmd       = pmwa_pkg::CMD_RSRD;
        state_nxt = S_RSWR;
      end
      S_RSWR: begin
        cmd = pmwa_pkg::CMD_RSWR;
        state_nxt = stat.i_last ? S_LINK : S_RSRD;
      end
      S_CLF: begin
        cmd = pmwa_pkg::CMD_CLF;
        if (stat.i_last) state_nxt = S_LINK;
      end
      S_LINK: begin
        cmd = pmwa_pkg::CMD_LINK;
        state_nxt = stat.lvl_last ? S_ACC : S_WRD;
      end
      S_ACC: begin
        cmd = pmwa_pkg::CMD_ACC;
        state_nxt = stat.is_write ? S_DONE : S_ACCW;
      end
      S_ACCW: begin
        cmd       = pmwa_pkg::CMD_ACCW;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd = pmwa_pkg::CMD_DONE;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
endmodule
`default_nettype wire
